// ----- src/ols_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types, widths and helpers for the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        MODE_INS_FRONT = 2'd0,
        MODE_INS_END   = 2'd1,
        MODE_DELETE    = 2'd2,
        MODE_DUMP      = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DEL  = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] value;
        logic [4:0]         position;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic               item_valid;
        logic signed [31:0] item_value;
        logic               last;
    } t_out;

    // head + logical index folded back into the ring
    function automatic logic [PTR_W-1:0] f_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = s;
        if (s >= SUM_W'(CAPACITY)) begin
            t = s - SUM_W'(CAPACITY);
        end
        return t[PTR_W-1:0];
    endfunction

endpackage

// ----- src/ordered_list_store_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store_unit
// Bounded ordered list kept in a ring buffer with a head pointer.
// ----------------------------------------------------------------------------
// Insert, rejected ops and empty dump: result valid the cycle after accept.
// Delete at position p below count: count-p read/move steps, a closing write and a finish
// step that waits for a free output; when p is the last entry only the finish step runs.
// Dump: count beats, one per cycle when not stalled; the head entry is read at accept.
// One item at a time; reset clears count, head and control, no clearing pass.
module ordered_list_store_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ols_pkg::t_in    i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ols_pkg::t_out   o_out
);

    logic [ols_pkg::VAL_W-1:0] r_mem [ols_pkg::CAPACITY];
    logic [ols_pkg::VAL_W-1:0] r_rd_data;

    ols_pkg::t_state             r_state, n_state;
    logic [ols_pkg::PTR_W-1:0]   r_head, n_head;
    logic [ols_pkg::CNT_W-1:0]   r_count, n_count;
    logic [ols_pkg::PTR_W-1:0]   r_idx, n_idx;
    logic                        r_wr_pend, n_wr_pend;
    logic [ols_pkg::PTR_W-1:0]   r_wr_idx, n_wr_idx;
    ols_pkg::t_out               r_out, n_out;
    logic                        r_out_valid, n_out_valid;

    logic                        out_free;
    logic                        in_take;
    logic [ols_pkg::CNT_W-1:0]   idx_nxt;
    logic [ols_pkg::PTR_W-1:0]   head_dec;
    logic                        we;
    logic [ols_pkg::PTR_W-1:0]   waddr;
    logic [ols_pkg::VAL_W-1:0]   wdata;
    logic                        re;
    logic [ols_pkg::PTR_W-1:0]   raddr;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == ols_pkg::S_IDLE) && out_free);
    assign in_take     = i_in_valid && !o_in_stall;
    assign idx_nxt     = ols_pkg::CNT_W'(r_idx) + ols_pkg::CNT_W'(1);
    assign head_dec    = (r_head == '0) ? ols_pkg::PTR_W'(ols_pkg::CAPACITY - 1)
                                        : r_head - ols_pkg::PTR_W'(1);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_wr_pend   = r_wr_pend;
        n_wr_idx    = r_wr_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        we          = 1'b0;
        waddr       = ols_pkg::f_wrap(ols_pkg::SUM_W'(r_head) + ols_pkg::SUM_W'(r_wr_idx));
        wdata       = r_rd_data;
        re          = 1'b0;
        raddr       = ols_pkg::f_wrap(ols_pkg::SUM_W'(r_head) + ols_pkg::SUM_W'(idx_nxt));

        unique case (r_state)
            ols_pkg::S_IDLE: begin
                if (in_take) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = ols_pkg::ST_OK;
                    n_out.item_valid  = 1'b0;
                    n_out.item_value  = '0;
                    n_out.last        = 1'b1;
                    unique case (i_in.mode) inside
                        ols_pkg::MODE_INS_FRONT, ols_pkg::MODE_INS_END: begin
                            if (r_count == ols_pkg::CNT_W'(ols_pkg::CAPACITY)) begin
                                n_out.status = ols_pkg::ST_FULL;
                            end else begin
                                we      = 1'b1;
                                wdata   = i_in.value;
                                n_count = r_count + ols_pkg::CNT_W'(1);
                                if (i_in.mode == ols_pkg::MODE_INS_FRONT) begin
                                    waddr  = head_dec;
                                    n_head = head_dec;
                                end else begin
                                    waddr = ols_pkg::f_wrap(ols_pkg::SUM_W'(r_head)
                                                            + ols_pkg::SUM_W'(r_count));
                                end
                            end
                        end
                        ols_pkg::MODE_DELETE: begin
                            if (r_count == '0) begin
                                n_out.status = ols_pkg::ST_EMPTY;
                            end else if (i_in.position == '0 ||
                                         ols_pkg::CMP_W'(i_in.position) >
                                         ols_pkg::CMP_W'(r_count)) begin
                                n_out.status = ols_pkg::ST_INVALID;
                            end else begin
                                // result comes when the gap is closed
                                n_out_valid = 1'b0;
                                n_idx       = ols_pkg::PTR_W'(i_in.position - 5'd1);
                                n_wr_pend   = 1'b0;
                                n_state     = ols_pkg::S_DEL;
                            end
                        end
                        ols_pkg::MODE_DUMP: begin
                            if (r_count == '0) begin
                                n_out.status = ols_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                re          = 1'b1;
                                raddr       = r_head;
                                n_idx       = '0;
                                n_state     = ols_pkg::S_DUMP;
                            end
                        end
                        default: begin
                            n_out.status = ols_pkg::ST_INVALID;
                        end
                    endcase
                end
            end

            ols_pkg::S_DEL: begin
                // read entry i+1 this cycle, write it to slot i the next
                if (r_wr_pend) begin
                    we        = 1'b1;
                    n_wr_pend = 1'b0;
                end
                if (idx_nxt < r_count) begin
                    re        = 1'b1;
                    n_wr_pend = 1'b1;
                    n_wr_idx  = r_idx;
                    n_idx     = idx_nxt[ols_pkg::PTR_W-1:0];
                end else if (!r_wr_pend && out_free) begin
                    n_count          = r_count - ols_pkg::CNT_W'(1);
                    n_out_valid      = 1'b1;
                    n_out.status     = ols_pkg::ST_OK;
                    n_out.item_valid = 1'b0;
                    n_out.item_value = '0;
                    n_out.last       = 1'b1;
                    n_state          = ols_pkg::S_IDLE;
                end
            end

            ols_pkg::S_DUMP: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = ols_pkg::ST_OK;
                    n_out.item_valid = 1'b1;
                    n_out.item_value = r_rd_data;
                    n_out.last       = (idx_nxt == r_count);
                    if (idx_nxt == r_count) begin
                        n_state = ols_pkg::S_IDLE;
                    end else begin
                        re    = 1'b1;
                        n_idx = idx_nxt[ols_pkg::PTR_W-1:0];
                    end
                end
            end

            default: begin
                n_state = ols_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ols_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_wr_pend   <= 1'b0;
            r_wr_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_wr_pend   <= n_wr_pend;
            r_wr_idx    <= n_wr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // ring storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ordered_list_store_unit. A list tracker predicts
// every result beat and compares the beats that come out, field by field.
// Stimulus is a short directed pass over the corner cases, then a fill to
// capacity, a long output hold-off, and phases of random operations, some biased
// to grow or shrink the list.
// ----------------------------------------------------------------------------
module testbench;
    import ols_pkg::*;

    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_OPS      = 24;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    class list_tracker;
        logic signed [31:0] stored_values[$];
        t_out               expected_beats[$];
        int errors;
        int ops_seen;
        int beats_checked;
        int full_rejects;
        int bad_positions;
        int empty_hits;
        int longest_dump;

        function void expect_beat(t_status st, logic valid, logic signed [31:0] val,
                                  logic last);
            t_out b;
            b.status     = st;
            b.item_valid = valid;
            b.item_value = val;
            b.last       = last;
            expected_beats.push_back(b);
        endfunction

        function void note_op(t_in op);
            int n;
            n = stored_values.size();
            ops_seen++;
            case (op.mode)
                MODE_INS_FRONT, MODE_INS_END: begin
                    if (n >= CAPACITY) begin
                        full_rejects++;
                        expect_beat(ST_FULL, 1'b0, '0, 1'b1);
                    end else begin
                        if (op.mode == MODE_INS_FRONT) begin
                            stored_values.push_front(op.value);
                        end else begin
                            stored_values.push_back(op.value);
                        end
                        expect_beat(ST_OK, 1'b0, '0, 1'b1);
                    end
                end
                MODE_DELETE: begin
                    // empty wins over a bad position
                    if (n == 0) begin
                        empty_hits++;
                        expect_beat(ST_EMPTY, 1'b0, '0, 1'b1);
                    end else if (op.position == 0 || op.position > n) begin
                        bad_positions++;
                        expect_beat(ST_INVALID, 1'b0, '0, 1'b1);
                    end else begin
                        stored_values.delete(op.position - 1);
                        expect_beat(ST_OK, 1'b0, '0, 1'b1);
                    end
                end
                default: begin
                    if (n == 0) begin
                        empty_hits++;
                        expect_beat(ST_EMPTY, 1'b0, '0, 1'b1);
                    end else begin
                        if (n > longest_dump) longest_dump = n;
                        for (int i = 0; i < n; i++) begin
                            expect_beat(ST_OK, 1'b1, stored_values[i], i == n - 1);
                        end
                    end
                end
            endcase
        endfunction

        function void check_beat(t_out got);
            t_out want;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: status %0d value %0d",
                       got.status, got.item_value);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.item_valid !== want.item_valid) begin
                $error("item_valid: expected %0d, got %0d", want.item_valid, got.item_valid);
                errors++;
            end
            if (got.item_value !== want.item_value) begin
                $error("item_value: expected %0d, got %0d", want.item_value, got.item_value);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    t_in   in_beat   = '0;
    logic  out_stall = 1'b0;
    logic  in_stall;
    logic  out_valid;
    t_out  out_beat;

    bit    no_idle   = 1'b0;
    bit    hold_req  = 1'b0;
    int    idle_cycles = 0;
    list_tracker book = new;

    ordered_list_store_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        return no_idle ? 0 : int'($urandom_range(0, 4));
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in make_op(t_mode m, logic signed [31:0] v, logic [4:0] p);
        t_in op;
        op.mode     = m;
        op.value    = v;
        op.position = p;
        return op;
    endfunction

    // valid stays high across back-to-back beats, so it is only lowered
    // when a gap actually follows
    task automatic send_op(t_in op);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= op;
        do @(posedge clk); while (in_stall !== 1'b0);
        book.note_op(op);
    endtask

    task automatic drain(int settle);
        in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic random_phase(t_mix mix, int count);
        int    r;
        int    n;
        t_mode m;
        logic [4:0] p;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            case (mix)
                MIX_GROW:   m = (r < 35) ? MODE_INS_FRONT : (r < 70) ? MODE_INS_END :
                                (r < 85) ? MODE_DELETE : MODE_DUMP;
                MIX_SHRINK: m = (r < 10) ? MODE_INS_FRONT : (r < 20) ? MODE_INS_END :
                                (r < 80) ? MODE_DELETE : MODE_DUMP;
                default:    m = t_mode'(r % 4);
            endcase
            n = book.stored_values.size();
            if (n > 0 && $urandom_range(0, 9) < 8) begin
                p = 5'($urandom_range(1, n));
            end else begin
                p = 5'($urandom_range(0, 16));
            end
            send_op(make_op(m, rand_value(), p));
        end
    endtask

    // output side: one drawn wait per beat, plus the long hold-off on request
    initial begin
        int wait_cycles;
        bit taken;
        wait (rst_n === 1'b1);
        forever begin
            wait_cycles = pick_gap();
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            taken = 1'b0;
            while (!taken) begin
                @(posedge clk);
                if (out_valid === 1'b1) begin
                    book.check_beat(out_beat);
                    taken = 1'b1;
                end else if (hold_req) begin
                    hold_req = 1'b0;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_stall === 1'b0) ||
            (out_valid === 1'b1 && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corners
        send_op(make_op(MODE_DUMP,      32'sd5, 5'd0));
        send_op(make_op(MODE_DELETE,    32'sd0, 5'd1));
        send_op(make_op(MODE_DELETE,    -32'sd1, 5'd16));
        // value extremes at both ends
        send_op(make_op(MODE_INS_FRONT, 32'sh7fff_ffff, 5'd31));
        send_op(make_op(MODE_INS_END,   32'sh8000_0000, 5'd0));
        send_op(make_op(MODE_INS_FRONT, -32'sd1, 5'd16));
        send_op(make_op(MODE_INS_END,   32'sd0, 5'd3));
        send_op(make_op(MODE_DUMP,      32'sd0, 5'd0));
        // positions out of range
        send_op(make_op(MODE_DELETE,    32'sd0, 5'd0));
        send_op(make_op(MODE_DELETE,    32'sd0, 5'd5));
        send_op(make_op(MODE_DELETE,    32'sd0, 5'd16));
        // last, then first entry
        send_op(make_op(MODE_DELETE,    32'sd0, 5'd4));
        send_op(make_op(MODE_DELETE,    32'sd0, 5'd1));
        send_op(make_op(MODE_DUMP,      32'sd0, 5'd0));
        send_op(make_op(MODE_DELETE,    32'sd0, 5'd2));
        send_op(make_op(MODE_DELETE,    32'sd0, 5'd1));
        send_op(make_op(MODE_DUMP,      32'sd0, 5'd0));

        // fill to capacity, then knock on the full store
        while (book.stored_values.size() < CAPACITY) begin
            send_op(make_op($urandom_range(0, 1) ? MODE_INS_END : MODE_INS_FRONT,
                            rand_value(), 5'($urandom_range(0, 16))));
        end
        send_op(make_op(MODE_INS_FRONT, rand_value(), 5'd0));
        send_op(make_op(MODE_INS_END,   rand_value(), 5'd0));
        send_op(make_op(MODE_DUMP,      rand_value(), 5'd0));
        send_op(make_op(MODE_DELETE,    rand_value(), 5'(CAPACITY)));
        send_op(make_op(MODE_DELETE,    rand_value(), 5'd8));
        send_op(make_op(MODE_INS_END,   rand_value(), 5'd0));
        drain(4);

        // output held off while input keeps coming back to back
        hold_req = 1'b1;
        no_idle  = 1'b1;
        send_op(make_op(MODE_DUMP,      rand_value(), 5'd0));
        send_op(make_op(MODE_DELETE,    rand_value(), 5'd1));
        send_op(make_op(MODE_INS_FRONT, rand_value(), 5'd0));
        send_op(make_op(MODE_DUMP,      rand_value(), 5'd0));
        send_op(make_op(MODE_DELETE,    rand_value(), 5'd9));
        send_op(make_op(MODE_DUMP,      rand_value(), 5'd0));
        no_idle  = 1'b0;
        drain(4);

        random_phase(MIX_SHRINK, PHASE_OPS);
        random_phase(MIX_GROW,   PHASE_OPS);
        drain(4);
        no_idle = 1'b1;
        random_phase(MIX_EVEN,   PHASE_OPS);
        no_idle = 1'b0;
        random_phase(MIX_GROW,   PHASE_OPS);
        random_phase(MIX_SHRINK, PHASE_OPS);
        drain(4);
        random_phase(MIX_EVEN,   PHASE_OPS);
        random_phase(MIX_GROW,   PHASE_OPS / 2);
        random_phase(MIX_SHRINK, PHASE_OPS / 2);

        drain(SETTLE_CYCLES);
        $display("ran %0d list operations, checked %0d result beats, longest dump %0d",
                 book.ops_seen, book.beats_checked, book.longest_dump);
        $display("full rejects %0d, bad positions %0d, empty list hits %0d",
                 book.full_rejects, book.bad_positions, book.empty_hits);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
